### src/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int DEF_WIDTH = 32;
    localparam int MW = 64;
    localparam int CW = 7;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
        CMD_CMP = 3'd4, CMD_NEG = 3'd5, CMD_ABS = 3'd6, CMD_RED = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_ZDEN = 2'd2
    } t_status;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_GCD, S_DIVN, S_DIVD, S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic [1:0] mul_sel;
        logic sum;
        logic gcd_start;
        logic div_start;
        logic div_sel;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic unit_done;
    } t_stat;
endpackage
`default_nettype wire

### src/rau_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, serial multiplier, binary gcd and restoring divider.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rau_pkg::t_ctrl     i_ctrl,
    output rau_pkg::t_stat          o_stat,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [31:0] i_x_num,
    input  wire logic signed [31:0] i_x_den,
    input  wire logic signed [31:0] i_y_num,
    input  wire logic signed [31:0] i_y_den,
    output logic                    o_valid,
    output logic signed [31:0]      o_res_num,
    output logic [30:0]             o_res_den,
    output logic [1:0]              o_cmp_code,
    output logic [1:0]              o_status
);
    import rau_pkg::*;

    localparam logic [MW-1:0] LIM = MW'(1) << (WIDTH - 1);

    logic [2:0]  r_cmd;
    logic [31:0] r_ma, r_mb, r_mc, r_md;
    logic        r_sa, r_sb, r_sc, r_sd;
    logic [MW-1:0] r_p0, r_p1, r_p2;
    logic        r_s0, r_s1, r_s2;
    logic [MW-1:0] r_nm, r_dm;
    logic        r_nn, r_dn;

    // serial multiplier
    logic [31:0]   r_mx, r_my;
    logic [MW-1:0] r_acc;
    logic [5:0]    r_mcnt;
    logic          r_mbusy;
    logic [1:0]    r_msel;

    // gcd
    logic [MW-1:0] r_ga, r_gb;
    logic [CW-1:0] r_gk;
    logic          r_gbusy;
    // divider
    logic [MW-1:0] r_q, r_rem, r_dv;
    logic [CW-1:0] r_dcnt;
    logic          r_dbusy, r_dsel;
    logic [MW-1:0] r_g;

    logic [MW-1:0] n_nm;
    logic          n_nn;
    logic [MW:0]   w_rs;

    always_comb begin
        n_nn = r_s0;
        logic_sum: begin
            logic s1;
            s1 = (r_cmd == CMD_SUB && r_p1 != '0) ? ~r_s1 : r_s1;
            if (r_s0 == s1) begin
                n_nm = r_p0 + r_p1;
            end else if (r_p0 >= r_p1) begin
                n_nm = r_p0 - r_p1;
            end else begin
                n_nm = r_p1 - r_p0;
                n_nn = s1;
            end
        end
    end

    assign w_rs = {r_rem, r_q[MW-1]} - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_gbusy <= 1'b0;
            r_dbusy <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctrl.emit;
            if (i_ctrl.load) begin
                r_cmd <= i_cmd;
                r_sa <= i_x_num[31]; r_ma <= i_x_num[31] ? 32'(-i_x_num) : i_x_num;
                r_sb <= i_x_den[31]; r_mb <= i_x_den[31] ? 32'(-i_x_den) : i_x_den;
                r_sc <= i_y_num[31]; r_mc <= i_y_num[31] ? 32'(-i_y_num) : i_y_num;
                r_sd <= i_y_den[31]; r_md <= i_y_den[31] ? 32'(-i_y_den) : i_y_den;
            end
            if (i_ctrl.mul_start) begin
                r_msel <= i_ctrl.mul_sel;
                r_mbusy <= 1'b1;
                r_mcnt <= '0;
                r_acc <= '0;
                unique case (i_ctrl.mul_sel)
                    2'd0: begin
                        r_mx <= r_ma;
                        r_my <= (r_cmd == CMD_MUL) ? r_mc : r_md;
                    end
                    2'd1: begin
                        r_mx <= r_mb;
                        r_my <= (r_cmd == CMD_MUL) ? r_md : r_mc;
                    end
                    default: begin
                        r_mx <= r_mb;
                        r_my <= (r_cmd == CMD_DIV) ? r_mc : r_md;
                    end
                endcase
            end else if (r_mbusy) begin
                if (r_my[0]) r_acc <= r_acc + ({32'd0, r_mx} << r_mcnt);
                r_my <= r_my >> 1;
                r_mcnt <= r_mcnt + 6'd1;
                if (r_mcnt == 6'd31) r_mbusy <= 1'b0;
            end
            if (!r_mbusy && !i_ctrl.mul_start && r_mcnt == 6'd32) begin
                r_mcnt <= 6'd33;
                unique case (r_msel)
                    2'd0: begin
                        r_p0 <= r_acc;
                        r_s0 <= (r_cmd == CMD_MUL) ? r_sa ^ r_sc : r_sa ^ r_sd;
                    end
                    2'd1: begin
                        r_p1 <= r_acc;
                        r_s1 <= (r_cmd == CMD_MUL) ? r_sb ^ r_sd : r_sb ^ r_sc;
                    end
                    default: begin
                        r_p2 <= r_acc;
                        r_s2 <= (r_cmd == CMD_DIV) ? r_sb ^ r_sc : r_sb ^ r_sd;
                    end
                endcase
            end
            if (i_ctrl.sum) begin
                unique case (r_cmd)
                    CMD_ADD, CMD_SUB: begin
                        r_nm <= n_nm; r_nn <= n_nn; r_dm <= r_p2; r_dn <= r_s2;
                    end
                    CMD_MUL, CMD_DIV: begin
                        r_nm <= r_p0; r_nn <= r_s0; r_dm <= r_p1; r_dn <= r_s1;
                    end
                    CMD_NEG: begin
                        r_nm <= MW'(r_ma); r_nn <= (r_ma != '0) ? ~r_sa : r_sa;
                        r_dm <= MW'(r_mb); r_dn <= r_sb;
                    end
                    CMD_ABS: begin
                        r_nm <= MW'(r_ma); r_nn <= 1'b0;
                        r_dm <= MW'(r_mb); r_dn <= 1'b0;
                    end
                    default: begin
                        r_nm <= MW'(r_ma); r_nn <= r_sa;
                        r_dm <= MW'(r_mb); r_dn <= r_sb;
                    end
                endcase
            end
            if (i_ctrl.gcd_start) begin
                r_ga <= r_nm; r_gb <= r_dm; r_gk <= '0; r_gbusy <= 1'b1;
            end else if (r_gbusy) begin
                if (r_ga == '0) begin
                    r_g <= r_gb << r_gk; r_gbusy <= 1'b0;
                end else if (r_gb == '0) begin
                    r_g <= r_ga << r_gk; r_gbusy <= 1'b0;
                end else if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= r_ga >> 1; r_gb <= r_gb >> 1; r_gk <= r_gk + CW'(1);
                end else if (!r_ga[0]) begin
                    r_ga <= r_ga >> 1;
                end else if (!r_gb[0]) begin
                    r_gb <= r_gb >> 1;
                end else if (r_ga >= r_gb) begin
                    r_ga <= (r_ga - r_gb) >> 1;
                end else begin
                    r_gb <= (r_gb - r_ga) >> 1;
                end
            end
            if (i_ctrl.div_start) begin
                r_dsel <= i_ctrl.div_sel;
                r_q <= i_ctrl.div_sel ? r_dm : r_nm;
                r_rem <= '0; r_dv <= r_g; r_dcnt <= '0; r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (!w_rs[MW]) begin
                    r_rem <= w_rs[MW-1:0];
                    r_q <= {r_q[MW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[MW-2:0], r_q[MW-1]};
                    r_q <= {r_q[MW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + CW'(1);
                if (r_dcnt == CW'(MW - 1)) r_dbusy <= 1'b0;
            end
            if (r_dbusy && r_dcnt == CW'(MW - 1)) begin
                if (!r_dsel) r_nm <= w_rs[MW] ? {r_q[MW-2:0], 1'b0} : {r_q[MW-2:0], 1'b1};
                else r_dm <= w_rs[MW] ? {r_q[MW-2:0], 1'b0} : {r_q[MW-2:0], 1'b1};
            end
        end
    end

    logic w_done;
    assign w_done = (!r_mbusy && r_mcnt == 6'd33) || !r_gbusy && !r_dbusy;
    assign o_stat.unit_done = !r_mbusy && !r_gbusy && !r_dbusy
                              && (r_mcnt != 6'd32) && !i_ctrl.mul_start
                              && !i_ctrl.gcd_start && !i_ctrl.div_start && w_done;

    logic          w_neg, w_ovf;
    logic signed [63:0] w_pa, w_pb;
    logic [1:0]    w_cc;
    assign w_pa = r_s0 ? -$signed(r_p0) : $signed(r_p0);
    assign w_pb = r_s1 ? -$signed(r_p1) : $signed(r_p1);
    always_comb begin
        if (w_pa == w_pb) w_cc = CMP_EQ;
        else if ((w_pa > w_pb) ^ (r_sb ^ r_sd)) w_cc = CMP_GT;
        else w_cc = CMP_LT;
    end
    assign w_neg = (r_nn != r_dn) && r_nm != '0;
    assign w_ovf = (r_dm > LIM - 1) || (w_neg ? r_nm > LIM : r_nm > LIM - 1);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            o_res_num  <= 32'sd0;
            o_res_den  <= 31'd1;
            o_cmp_code <= CMP_LT;
            if (r_cmd == CMD_CMP) begin
                if (r_mb == '0 || r_md == '0) o_status <= ST_ZDEN;
                else begin
                    o_status <= ST_OK;
                    o_cmp_code <= w_cc;
                end
            end else if (r_g == '0) begin
                o_status <= ST_ZDEN;
            end else if (r_dm == '0) begin
                o_status <= ST_ZDEN;
            end else if (w_ovf) begin
                o_status <= ST_OVF;
            end else begin
                o_status <= ST_OK;
                o_res_num <= w_neg ? 32'(-r_nm) : r_nm[31:0];
                o_res_den <= r_dm[30:0];
            end
        end
    end

`ifndef ASSERT_OFF
    a_mul_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mbusy && r_gbusy)) else $error("mul and gcd overlap");
    a_div_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_dbusy && r_gbusy)) else $error("div and gcd overlap");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> !r_dbusy && !r_gbusy) else $error("emit while busy");
`endif
endmodule
`default_nettype wire

### src/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for products, reduction and result emission.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2:0]     i_cmd,
    input  wire rau_pkg::t_stat i_stat,
    output rau_pkg::t_ctrl      o_ctrl,
    output logic                o_busy
);
    import rau_pkg::*;

    t_state r_state, n_state;
    logic   r_wait, n_wait;
    logic [2:0] r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
        if (i_start && r_state == S_IDLE) r_cmd <= i_cmd;
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        o_ctrl  = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state = S_MUL1;
                    n_wait = 1'b0;
                end
            end
            S_MUL1, S_MUL2, S_MUL3: begin
                if (!r_wait) begin
                    o_ctrl.mul_start = 1'b1;
                    o_ctrl.mul_sel = (r_state == S_MUL1) ? 2'd0 :
                                     (r_state == S_MUL2) ? 2'd1 : 2'd2;
                    n_wait = 1'b1;
                end else if (i_stat.unit_done) begin
                    n_wait = 1'b0;
                    if (r_state == S_MUL1) n_state = S_MUL2;
                    else if (r_state == S_MUL2)
                        n_state = (r_cmd == CMD_ADD || r_cmd == CMD_SUB) ? S_MUL3 : S_SUM;
                    else n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_ctrl.sum = 1'b1;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (!r_wait) begin
                    o_ctrl.gcd_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_stat.unit_done) begin
                    n_wait = 1'b0;
                    n_state = S_DIVN;
                end
            end
            S_DIVN, S_DIVD: begin
                if (!r_wait) begin
                    o_ctrl.div_start = 1'b1;
                    o_ctrl.div_sel = (r_state == S_DIVD);
                    n_wait = 1'b1;
                end else if (i_stat.unit_done) begin
                    n_wait = 1'b0;
                    n_state = (r_state == S_DIVN) ? S_DIVD : S_DONE;
                end
            end
            S_DONE: begin
                o_ctrl.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.emit |=> r_state == S_IDLE) else $error("emit not followed by idle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctrl.mul_start, o_ctrl.gcd_start, o_ctrl.div_start}))
        else $error("two units started");
`endif
endmodule
`default_nettype wire

### src/rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Rational add, subtract, multiply, divide, compare, negate, abs and reduce.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy low; one item at a time.
// The result shows for one cycle with o_valid and cannot be stalled. A
// request runs two or three 32x32 products in a shift-add multiplier, a
// binary gcd on 64-bit values, and two restoring divisions that reduce
// the fraction.
module rational_arithmetic_unit_top #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [31:0] i_x_num,
    input  wire logic signed [31:0] i_x_den,
    input  wire logic signed [31:0] i_y_num,
    input  wire logic signed [31:0] i_y_den,
    output logic                    o_valid,
    output logic signed [31:0]      o_res_num,
    output logic [30:0]             o_res_den,
    output logic [1:0]              o_cmp_code,
    output logic [1:0]              o_status
);
    import rau_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .i_stat(w_stat), .o_ctrl(w_ctrl), .o_busy(o_busy)
    );

    rau_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .o_stat(w_stat),
        .i_cmd(i_cmd), .i_x_num(i_x_num), .i_x_den(i_x_den),
        .i_y_num(i_y_num), .i_y_den(i_y_den), .o_valid(o_valid),
        .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_cmp_code(o_cmp_code), .o_status(o_status)
    );
endmodule
`default_nettype wire
